>>> sv/rgzc_pkg.sv
// ----------------------------------------------------------------------------
// Ranging grid zone classifier package
// Shared widths, register indexes, zone codes, reset values and record types.
// ----------------------------------------------------------------------------
package rgzc_pkg;

  localparam int GRID_ROWS      = 8;
  localparam int GRID_COLS      = 8;
  localparam int HEAD_ROWS      = 4;
  localparam int CONFIRM_FRAMES = 2;

  localparam int DIST_W    = 16;
  localparam int ROW_W     = $clog2(GRID_ROWS);
  localparam int WEIGHT_W  = 9;
  localparam int ZONE_W    = 2;
  localparam int CNT_W     = 2;
  localparam int REG_IDX_W = 3;
  localparam int PROD_W    = 24;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef logic [DIST_W-1:0]   dist_t;
  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic [ZONE_W-1:0]   zone_t;

  localparam dist_t              NO_READING = '1;
  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(GRID_ROWS - 1);
  localparam logic [ROW_W-1:0]   HEAD_LIMIT = ROW_W'(HEAD_ROWS);
  localparam weight_t            WEIGHT_ONE = 9'd256;
  localparam logic [CNT_W-1:0]   CONFIRM_CNT = CNT_W'(CONFIRM_FRAMES);

  // Register indexes on the configuration channel
  localparam logic [REG_IDX_W-1:0] REG_MAX_RANGE      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMMINENT_ENTER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IMMINENT_EXIT  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_ENTER     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NEAR_EXIT      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FAR_ENTER      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FAR_EXIT       = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SMOOTH_WEIGHT  = 3'd7;

  // Zone codes
  localparam zone_t ZONE_NONE     = 2'd0;
  localparam zone_t ZONE_FAR      = 2'd1;
  localparam zone_t ZONE_NEAR     = 2'd2;
  localparam zone_t ZONE_IMMINENT = 2'd3;

  // Register reset values
  localparam dist_t   RST_MAX_RANGE      = 16'd4000;
  localparam dist_t   RST_IMMINENT_ENTER = 16'd180;
  localparam dist_t   RST_IMMINENT_EXIT  = 16'd220;
  localparam dist_t   RST_NEAR_ENTER     = 16'd450;
  localparam dist_t   RST_NEAR_EXIT      = 16'd550;
  localparam dist_t   RST_FAR_ENTER      = 16'd950;
  localparam dist_t   RST_FAR_EXIT       = 16'd1050;
  localparam weight_t RST_SMOOTH_WEIGHT  = 9'd179;

  typedef struct packed {
    dist_t   max_range;
    dist_t   imminent_enter;
    dist_t   imminent_exit;
    dist_t   near_enter;
    dist_t   near_exit;
    dist_t   far_enter;
    dist_t   far_exit;
    weight_t smooth_weight;
  } cfg_t;

  // One closed frame (or a read failure) handed from front to back
  typedef struct packed {
    logic  fail;
    dist_t min_all;
    logic  head_seen;
    dist_t min_head;
    logic  waist_seen;
    dist_t min_waist;
  } frame_t;

  function automatic dist_t dist_min(dist_t a, dist_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> sv/rgzc_ifs.sv
// ----------------------------------------------------------------------------
// Ranging grid zone classifier channels
// Valid/ready interfaces for row items, result items and register writes.
// ----------------------------------------------------------------------------
interface rgzc_row_if import rgzc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             mode;
  logic [ROW_W-1:0] row_index;
  dist_t            cell0;
  dist_t            cell1;
  dist_t            cell2;
  dist_t            cell3;
  dist_t            cell4;
  dist_t            cell5;
  dist_t            cell6;
  dist_t            cell7;

  modport source (output valid, mode, row_index, cell0, cell1, cell2, cell3,
                  cell4, cell5, cell6, cell7, input ready);
  modport sink   (input valid, mode, row_index, cell0, cell1, cell2, cell3,
                  cell4, cell5, cell6, cell7, output ready);
endinterface

interface rgzc_out_if import rgzc_pkg::*; ();
  logic  valid;
  logic  ready;
  dist_t nearest_all;
  logic  head_seen;
  dist_t head_nearest;
  logic  waist_seen;
  dist_t waist_nearest;
  dist_t smooth_all;
  dist_t smooth_head;
  dist_t smooth_waist;
  zone_t zone;
  logic  read_failed;

  modport source (output valid, nearest_all, head_seen, head_nearest, waist_seen,
                  waist_nearest, smooth_all, smooth_head, smooth_waist, zone,
                  read_failed, input ready);
  modport sink   (input valid, nearest_all, head_seen, head_nearest, waist_seen,
                  waist_nearest, smooth_all, smooth_head, smooth_waist, zone,
                  read_failed, output ready);
endinterface

interface rgzc_cfg_if import rgzc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  dist_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/rgzc_front.sv
// ----------------------------------------------------------------------------
// Ranging grid zone classifier front end
// Reduces each row to lane minima, merges them into the running frame minima
// and hands closed frames and read failures to the queue.
// ----------------------------------------------------------------------------
module rgzc_front import rgzc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dist_t      max_range,
  rgzc_row_if.sink   rows,
  output logic       q_push,
  output frame_t     q_data,
  input  logic       q_full
);

  dist_t                 lane [GRID_COLS];
  logic [GRID_COLS-1:0]  lane_ok;
  dist_t                 row_min_all;
  dist_t                 row_min_mid;
  logic                  row_any_all;
  logic                  row_any_mid;

  // Row register
  logic             a_valid;
  logic             a_fail;
  logic [ROW_W-1:0] a_row;
  dist_t            a_min_all;
  dist_t            a_min_mid;
  logic             a_any_all;
  logic             a_any_mid;

  logic a_close;
  logic a_take;
  logic a_ready;

  // Running frame minima
  dist_t run_min_all;
  dist_t run_min_head;
  dist_t run_min_waist;
  logic  head_hit;
  logic  waist_hit;

  dist_t m_all;
  dist_t m_head;
  dist_t m_waist;
  logic  m_head_hit;
  logic  m_waist_hit;
  logic  a_is_head;

  // A cell counts when it is nonzero and within range; others read as no reading.
  always_comb begin
    lane[0] = rows.cell0;
    lane[1] = rows.cell1;
    lane[2] = rows.cell2;
    lane[3] = rows.cell3;
    lane[4] = rows.cell4;
    lane[5] = rows.cell5;
    lane[6] = rows.cell6;
    lane[7] = rows.cell7;
    for (int c = 0; c < GRID_COLS; c++) begin
      lane_ok[c] = (lane[c] != '0) && (lane[c] <= max_range);
      if (!lane_ok[c]) begin
        lane[c] = NO_READING;
      end
    end
    row_min_all = dist_min(dist_min(dist_min(lane[0], lane[1]), dist_min(lane[2], lane[3])),
                           dist_min(dist_min(lane[4], lane[5]), dist_min(lane[6], lane[7])));
    row_min_mid = dist_min(dist_min(lane[1], lane[2]),
                           dist_min(dist_min(lane[3], lane[4]), dist_min(lane[5], lane[6])));
    row_any_all = |lane_ok;
    row_any_mid = |lane_ok[GRID_COLS-2:1];
  end

  assign a_close   = a_fail || (a_row == LAST_ROW);
  assign a_take    = a_valid && (!a_close || !q_full);
  assign a_ready   = !a_valid || a_take;
  assign rows.ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= rows.valid;
    end
    if (rows.valid && a_ready) begin
      a_fail    <= rows.mode;
      a_row     <= rows.row_index;
      a_min_all <= row_min_all;
      a_min_mid <= row_min_mid;
      a_any_all <= row_any_all;
      a_any_mid <= row_any_mid;
    end
  end

  // Merge the registered row into the running frame state
  always_comb begin
    a_is_head   = a_row < HEAD_LIMIT;
    m_all       = dist_min(run_min_all, a_min_all);
    m_head      = a_is_head ? dist_min(run_min_head, a_min_all) : run_min_head;
    m_waist     = a_is_head ? run_min_waist : dist_min(run_min_waist, a_min_mid);
    m_head_hit  = head_hit || (a_is_head && a_any_all);
    m_waist_hit = waist_hit || (!a_is_head && a_any_mid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min_all   <= NO_READING;
      run_min_head  <= NO_READING;
      run_min_waist <= NO_READING;
      head_hit      <= 1'b0;
      waist_hit     <= 1'b0;
    end else if (a_take) begin
      if (a_close) begin
        run_min_all   <= NO_READING;
        run_min_head  <= NO_READING;
        run_min_waist <= NO_READING;
        head_hit      <= 1'b0;
        waist_hit     <= 1'b0;
      end else begin
        run_min_all   <= m_all;
        run_min_head  <= m_head;
        run_min_waist <= m_waist;
        head_hit      <= m_head_hit;
        waist_hit     <= m_waist_hit;
      end
    end
  end

  assign q_push = a_take && a_close;

  always_comb begin
    if (a_fail) begin
      q_data = '{fail: 1'b1, min_all: NO_READING, head_seen: 1'b0,
                 min_head: NO_READING, waist_seen: 1'b0, min_waist: NO_READING};
    end else begin
      q_data = '{fail: 1'b0, min_all: m_all, head_seen: m_head_hit,
                 min_head: m_head, waist_seen: m_waist_hit, min_waist: m_waist};
    end
  end

endmodule

>>> sv/rgzc_queue.sv
// ----------------------------------------------------------------------------
// Ranging grid zone classifier frame queue
// Short first-in first-out store of frame records between front and back.
// ----------------------------------------------------------------------------
module rgzc_queue import rgzc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_data,
  output logic   full,
  input  logic   pop,
  output logic   pop_valid,
  output frame_t pop_data
);

  frame_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     fill;

  assign full      = fill == (QUEUE_AW+1)'(QUEUE_DEPTH);
  assign pop_valid = fill != '0;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/rgzc_back.sv
// ----------------------------------------------------------------------------
// Ranging grid zone classifier back end
// Smooths the frame minima, runs the zone hysteresis and confirmation, and
// holds the result item until it is taken.
// ----------------------------------------------------------------------------
module rgzc_back import rgzc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  frame_t      q_data,
  output logic        q_pop,
  rgzc_out_if.source  result
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_AVG,
    ST_ZONE,
    ST_EMIT
  } state_t;

  state_t st;
  frame_t rec;

  logic [PROD_W-1:0] pn_all, pn_head, pn_waist;
  logic [PROD_W-1:0] po_all, po_head, po_waist;

  dist_t            avg_all;
  dist_t            avg_head;
  dist_t            avg_waist;
  zone_t            confirmed_zone;
  zone_t            shown_zone;
  logic [CNT_W-1:0] change_count;
  zone_t            zone_res;

  logic  out_valid;
  dist_t out_nearest_all;
  logic  out_head_seen;
  dist_t out_head_nearest;
  logic  out_waist_seen;
  dist_t out_waist_nearest;
  dist_t out_smooth_all;
  dist_t out_smooth_head;
  dist_t out_smooth_waist;
  zone_t out_zone;
  logic  out_read_failed;

  weight_t          w_new;
  weight_t          w_old;
  zone_t            raw_zone;
  logic [CNT_W-1:0] cnt_inc;
  zone_t            confirmed_next;
  zone_t            shown_next;
  logic [CNT_W-1:0] count_next;

  function automatic dist_t ema_pick(dist_t raw, dist_t prev,
                                     logic [PROD_W-1:0] pn, logic [PROD_W-1:0] po);
    logic [PROD_W-1:0] sum;
    sum = pn + po;
    if (raw == NO_READING) begin
      return NO_READING;
    end else if (prev == NO_READING) begin
      return raw;
    end else begin
      return sum[PROD_W-1:PROD_W-DIST_W];
    end
  endfunction

  assign w_new = (cfg.smooth_weight > WEIGHT_ONE) ? WEIGHT_ONE : cfg.smooth_weight;
  assign w_old = WEIGHT_ONE - w_new;

  // Hysteresis: thresholds depend on the zone already confirmed.
  always_comb begin
    unique case (confirmed_zone)
      ZONE_IMMINENT: begin
        raw_zone = (avg_all > cfg.imminent_exit) ? ZONE_NEAR : ZONE_IMMINENT;
      end
      ZONE_NEAR: begin
        priority if (avg_all <= cfg.imminent_enter) raw_zone = ZONE_IMMINENT;
        else if (avg_all > cfg.near_exit)           raw_zone = ZONE_FAR;
        else                                        raw_zone = ZONE_NEAR;
      end
      ZONE_FAR: begin
        priority if (avg_all <= cfg.near_enter) raw_zone = ZONE_NEAR;
        else if (avg_all > cfg.far_exit)        raw_zone = ZONE_NONE;
        else                                    raw_zone = ZONE_FAR;
      end
      ZONE_NONE: begin
        priority if (avg_all <= cfg.imminent_enter) raw_zone = ZONE_IMMINENT;
        else if (avg_all <= cfg.near_enter)         raw_zone = ZONE_NEAR;
        else if (avg_all <= cfg.far_enter)          raw_zone = ZONE_FAR;
        else                                        raw_zone = ZONE_NONE;
      end
    endcase
  end

  // A change must be seen on enough consecutive frames before it is taken.
  always_comb begin
    cnt_inc        = change_count + 1'b1;
    confirmed_next = confirmed_zone;
    shown_next     = shown_zone;
    count_next     = change_count;
    if (rec.min_all == NO_READING) begin
      confirmed_next = ZONE_NONE;
      shown_next     = ZONE_NONE;
      count_next     = '0;
    end else if (raw_zone != confirmed_zone) begin
      if (cnt_inc >= CONFIRM_CNT) begin
        confirmed_next = raw_zone;
        shown_next     = raw_zone;
        count_next     = '0;
      end else begin
        count_next = cnt_inc;
      end
    end else begin
      count_next = '0;
      shown_next = confirmed_zone;
    end
  end

  assign q_pop = (st == ST_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st             <= ST_IDLE;
      out_valid      <= 1'b0;
      avg_all        <= NO_READING;
      avg_head       <= NO_READING;
      avg_waist      <= NO_READING;
      confirmed_zone <= ZONE_NONE;
      shown_zone     <= ZONE_NONE;
      change_count   <= '0;
    end else begin
      // In the emit state the output register is reloaded below instead.
      if (out_valid && result.ready && (st != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (q_valid) begin
            rec <= q_data;
            if (q_data.fail) begin
              shown_zone <= ZONE_NONE;
              st         <= ST_EMIT;
            end else begin
              st <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          pn_all   <= PROD_W'(rec.min_all)   * PROD_W'(w_new);
          pn_head  <= PROD_W'(rec.min_head)  * PROD_W'(w_new);
          pn_waist <= PROD_W'(rec.min_waist) * PROD_W'(w_new);
          po_all   <= PROD_W'(avg_all)   * PROD_W'(w_old);
          po_head  <= PROD_W'(avg_head)  * PROD_W'(w_old);
          po_waist <= PROD_W'(avg_waist) * PROD_W'(w_old);
          st       <= ST_AVG;
        end
        ST_AVG: begin
          avg_all   <= ema_pick(rec.min_all, avg_all, pn_all, po_all);
          avg_head  <= ema_pick(rec.min_head, avg_head, pn_head, po_head);
          avg_waist <= ema_pick(rec.min_waist, avg_waist, pn_waist, po_waist);
          st        <= ST_ZONE;
        end
        ST_ZONE: begin
          confirmed_zone <= confirmed_next;
          shown_zone     <= shown_next;
          change_count   <= count_next;
          zone_res       <= shown_next;
          st             <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || result.ready) begin
            out_valid         <= 1'b1;
            out_nearest_all   <= rec.min_all;
            out_head_seen     <= rec.head_seen;
            out_head_nearest  <= rec.min_head;
            out_waist_seen    <= rec.waist_seen;
            out_waist_nearest <= rec.min_waist;
            out_smooth_all    <= avg_all;
            out_smooth_head   <= avg_head;
            out_smooth_waist  <= avg_waist;
            out_zone          <= rec.fail ? ZONE_NONE : zone_res;
            out_read_failed   <= rec.fail;
            st                <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign result.valid         = out_valid;
  assign result.nearest_all   = out_nearest_all;
  assign result.head_seen     = out_head_seen;
  assign result.head_nearest  = out_head_nearest;
  assign result.waist_seen    = out_waist_seen;
  assign result.waist_nearest = out_waist_nearest;
  assign result.smooth_all    = out_smooth_all;
  assign result.smooth_head   = out_smooth_head;
  assign result.smooth_waist  = out_smooth_waist;
  assign result.zone          = out_zone;
  assign result.read_failed   = out_read_failed;

endmodule

>>> sv/ranging_grid_zone_classifier.sv
// ----------------------------------------------------------------------------
// Ranging grid zone classifier
// Nearest-object extraction, smoothing and zone classification for an 8x8
// range sensor frame delivered one row per item.
// ----------------------------------------------------------------------------
// Usage. The rows channel takes one item per row: mode 0 carries the eight
// cells of row row_index, mode 1 reports a failed frame read. The item for the
// last row closes the frame and causes one result item on the result channel;
// a failure item causes one result item at once and discards the partial frame.
// Items for the other rows cause no result.
// Throughput: one row item per cycle while rows.ready is high. The back end
// steps through take, multiply, average, zone and emit for each closed frame
// and through take and emit for a failure, and a four-deep queue absorbs
// bursts, so full frames of eight rows stream without a stall; closing items
// that outpace the back end fill the queue and then hold rows.ready low.
// A closing item passes the row register, the queue and the back end states
// before result.valid rises; a failure item skips multiply, average and zone.
// Reset (synchronous, rst high) restores the register file to its defaults and
// clears the running minima, the averages and the zone state. A receiver that
// holds result.ready low keeps the result item stable; the back end then waits,
// the queue fills and only after that does the row channel stall.
// Registers are written through cfg at any time the block is idle; cfg.ready is
// always high.
// ----------------------------------------------------------------------------
module ranging_grid_zone_classifier import rgzc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rgzc_row_if.sink    rows,
  rgzc_out_if.source  result,
  rgzc_cfg_if.sink    cfg
);

  // Register file. Each write lands on the edge where cfg.valid is seen high.
  cfg_t regs;

  // Front to queue and queue to back
  logic   q_push;
  frame_t q_push_data;
  logic   q_full;
  logic   q_pop;
  logic   q_valid;
  frame_t q_pop_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_range      <= RST_MAX_RANGE;
      regs.imminent_enter <= RST_IMMINENT_ENTER;
      regs.imminent_exit  <= RST_IMMINENT_EXIT;
      regs.near_enter     <= RST_NEAR_ENTER;
      regs.near_exit      <= RST_NEAR_EXIT;
      regs.far_enter      <= RST_FAR_ENTER;
      regs.far_exit       <= RST_FAR_EXIT;
      regs.smooth_weight  <= RST_SMOOTH_WEIGHT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_MAX_RANGE:      regs.max_range      <= cfg.data;
        REG_IMMINENT_ENTER: regs.imminent_enter <= cfg.data;
        REG_IMMINENT_EXIT:  regs.imminent_exit  <= cfg.data;
        REG_NEAR_ENTER:     regs.near_enter     <= cfg.data;
        REG_NEAR_EXIT:      regs.near_exit      <= cfg.data;
        REG_FAR_ENTER:      regs.far_enter      <= cfg.data;
        REG_FAR_EXIT:       regs.far_exit       <= cfg.data;
        REG_SMOOTH_WEIGHT:  regs.smooth_weight  <= cfg.data[WEIGHT_W-1:0];
      endcase
    end
  end

  // The front end reduces each row to its minima in the row register and folds
  // them from there into the running frame state.
  rgzc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .max_range (regs.max_range),
    .rows      (rows),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_full    (q_full)
  );

  // Closed frames wait here so that a slow receiver does not stall rows at once.
  rgzc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_pop_data)
  );

  // The back end owns the averages and the zone state and drives the result.
  rgzc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .q_valid (q_valid),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .result  (result)
  );

endmodule

>>> sv/rgzc_checker.sv
// ----------------------------------------------------------------------------
// Ranging grid zone classifier checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rgzc_checker import rgzc_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  result_valid,
  input logic  result_ready,
  input dist_t nearest_all,
  input logic  head_seen,
  input dist_t head_nearest,
  input logic  waist_seen,
  input dist_t waist_nearest,
  input dist_t smooth_all,
  input zone_t zone,
  input logic  read_failed
);

  // A stalled result item is held unchanged.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(nearest_all) && $stable(zone) && $stable(smooth_all))
    else $error("result item changed while stalled");

  // A failure result reports no readings and no zone.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    result_valid && read_failed |->
      nearest_all == NO_READING && !head_seen && !waist_seen && zone == ZONE_NONE)
    else $error("failure result carries readings");

  // A region minimum exists only where a cell of that region was seen.
  a_seen_minima: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((!head_seen && head_nearest != NO_READING) ||
                     (!waist_seen && waist_nearest != NO_READING)) |-> 1'b0)
    else $error("region minimum without a seen cell");

  // An empty frame drops the zone; a frame with a reading has a defined average.
  a_empty_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && !read_failed |->
      (nearest_all == NO_READING && zone == ZONE_NONE && smooth_all == NO_READING) ||
      (nearest_all != NO_READING && smooth_all != NO_READING))
    else $error("zone or average inconsistent with frame minimum");

endmodule

bind ranging_grid_zone_classifier rgzc_checker u_rgzc_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result.valid),
  .result_ready  (result.ready),
  .nearest_all   (result.nearest_all),
  .head_seen     (result.head_seen),
  .head_nearest  (result.head_nearest),
  .waist_seen    (result.waist_seen),
  .waist_nearest (result.waist_nearest),
  .smooth_all    (result.smooth_all),
  .zone          (result.zone),
  .read_failed   (result.read_failed)
);

>>> tb/rgzc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zone classifier scoreboard
// Follows the row, result and register channels, works out each frame report
// from its own copy of the block state and compares it with what arrives.
// ----------------------------------------------------------------------------
module rgzc_scoreboard import rgzc_pkg::*; (
  input  logic clk,
  input  logic rst,
  rgzc_row_if  rows,
  rgzc_out_if  result,
  rgzc_cfg_if  cfg,
  output int   errors,
  output int   pending
);

  typedef dist_t [GRID_COLS-1:0] row_cells_t;

  typedef struct packed {
    dist_t nearest_all;
    logic  head_seen;
    dist_t head_nearest;
    logic  waist_seen;
    dist_t waist_nearest;
    dist_t smooth_all;
    dist_t smooth_head;
    dist_t smooth_waist;
    zone_t zone;
    logic  read_failed;
  } frame_report_t;

  cfg_t             regs;
  dist_t            min_all, min_head, min_waist;
  logic             head_hit, waist_hit;
  dist_t            avg_all, avg_head, avg_waist;
  zone_t            confirmed, shown;
  logic [CNT_W-1:0] change_cnt;
  frame_report_t    reports_due [$];

  task automatic clear_frame();
    min_all   = NO_READING;
    min_head  = NO_READING;
    min_waist = NO_READING;
    head_hit  = 1'b0;
    waist_hit = 1'b0;
  endtask

  // Exponential average with the new-sample weight saturated at one.
  function automatic dist_t smooth(input dist_t raw, input dist_t prev);
    int unsigned w, acc;
    w = (regs.smooth_weight > WEIGHT_ONE) ? 256 : int'(regs.smooth_weight);
    if (raw == NO_READING) return NO_READING;
    if (prev == NO_READING) return raw;
    acc = int'(raw) * w + int'(prev) * (256 - w);
    return dist_t'(acc >> 8);
  endfunction

  // Hysteresis: the thresholds that apply depend on the confirmed zone.
  function automatic zone_t zone_after(input dist_t d);
    case (confirmed)
      ZONE_IMMINENT: begin
        return (d > regs.imminent_exit) ? ZONE_NEAR : ZONE_IMMINENT;
      end
      ZONE_NEAR: begin
        if (d <= regs.imminent_enter) return ZONE_IMMINENT;
        if (d > regs.near_exit) return ZONE_FAR;
        return ZONE_NEAR;
      end
      ZONE_FAR: begin
        if (d <= regs.near_enter) return ZONE_NEAR;
        if (d > regs.far_exit) return ZONE_NONE;
        return ZONE_FAR;
      end
      default: begin
        if (d <= regs.imminent_enter) return ZONE_IMMINENT;
        if (d <= regs.near_enter) return ZONE_NEAR;
        if (d <= regs.far_enter) return ZONE_FAR;
        return ZONE_NONE;
      end
    endcase
  endfunction

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input dist_t value);
    case (idx)
      REG_MAX_RANGE:      regs.max_range      = value;
      REG_IMMINENT_ENTER: regs.imminent_enter = value;
      REG_IMMINENT_EXIT:  regs.imminent_exit  = value;
      REG_NEAR_ENTER:     regs.near_enter     = value;
      REG_NEAR_EXIT:      regs.near_exit      = value;
      REG_FAR_ENTER:      regs.far_enter      = value;
      REG_FAR_EXIT:       regs.far_exit       = value;
      default:            regs.smooth_weight  = value[WEIGHT_W-1:0];
    endcase
  endtask

  task automatic fold_row(input logic fail, input logic [ROW_W-1:0] row,
                          input row_cells_t cells);
    frame_report_t rep;
    dist_t         d;
    zone_t         step;
    if (fail) begin
      // A failed read drops the partial frame and blanks the shown zone only.
      clear_frame();
      shown = ZONE_NONE;
      rep = '{NO_READING, 1'b0, NO_READING, 1'b0, NO_READING,
              avg_all, avg_head, avg_waist, ZONE_NONE, 1'b1};
      reports_due.push_back(rep);
      return;
    end
    for (int col = 0; col < GRID_COLS; col++) begin
      d = cells[col];
      if (d == '0 || d > regs.max_range) continue;
      if (d < min_all) min_all = d;
      if (row < HEAD_LIMIT) begin
        head_hit = 1'b1;
        if (d < min_head) min_head = d;
      end else if (col >= 1 && col <= GRID_COLS - 2) begin
        waist_hit = 1'b1;
        if (d < min_waist) min_waist = d;
      end
    end
    if (row != LAST_ROW) return;

    avg_head  = smooth(min_head, avg_head);
    avg_waist = smooth(min_waist, avg_waist);
    avg_all   = smooth(min_all, avg_all);
    if (min_all != NO_READING) begin
      step = zone_after(avg_all);
      if (step != confirmed) begin
        change_cnt = change_cnt + 1'b1;
        if (change_cnt >= CONFIRM_CNT) begin
          confirmed  = step;
          shown      = step;
          change_cnt = '0;
        end
      end else begin
        change_cnt = '0;
        shown      = confirmed;
      end
    end else begin
      confirmed  = ZONE_NONE;
      shown      = ZONE_NONE;
      change_cnt = '0;
    end
    rep = '{min_all, head_hit, min_head, waist_hit, min_waist,
            avg_all, avg_head, avg_waist, shown, 1'b0};
    reports_due.push_back(rep);
    clear_frame();
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("rgzc_checker: %s expected %0d, got %0d at %0t", name, want, got, $time);
    end
  endtask

  always @(posedge clk) begin
    frame_report_t want;
    if (rst) begin
      regs = '{RST_MAX_RANGE, RST_IMMINENT_ENTER, RST_IMMINENT_EXIT, RST_NEAR_ENTER,
               RST_NEAR_EXIT, RST_FAR_ENTER, RST_FAR_EXIT, RST_SMOOTH_WEIGHT};
      clear_frame();
      avg_all    = NO_READING;
      avg_head   = NO_READING;
      avg_waist  = NO_READING;
      confirmed  = ZONE_NONE;
      shown      = ZONE_NONE;
      change_cnt = '0;
      reports_due.delete();
      errors     = 0;
    end else begin
      if (cfg.valid && cfg.ready) write_reg(cfg.index, cfg.data);
      if (result.valid && result.ready) begin
        if (reports_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("rgzc_checker: unexpected result at %0t", $time);
        end else begin
          want = reports_due.pop_front();
          check_field("nearest_all", want.nearest_all, result.nearest_all);
          check_field("head_seen", want.head_seen, result.head_seen);
          check_field("head_nearest", want.head_nearest, result.head_nearest);
          check_field("waist_seen", want.waist_seen, result.waist_seen);
          check_field("waist_nearest", want.waist_nearest, result.waist_nearest);
          check_field("smooth_all", want.smooth_all, result.smooth_all);
          check_field("smooth_head", want.smooth_head, result.smooth_head);
          check_field("smooth_waist", want.smooth_waist, result.smooth_waist);
          check_field("zone", want.zone, result.zone);
          check_field("read_failed", want.read_failed, result.read_failed);
        end
      end
      if (rows.valid && rows.ready)
        fold_row(rows.mode, rows.row_index,
                 {rows.cell7, rows.cell6, rows.cell5, rows.cell4,
                  rows.cell3, rows.cell2, rows.cell1, rows.cell0});
    end
    pending = reports_due.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Zone classifier testbench
// Drives row items and register writes into the classifier, applies random
// back-pressure on the result channel and leaves checking to the scoreboard
// and a watchdog; the scoreboard's error and pending counts decide the verdict.
// ----------------------------------------------------------------------------
module tb;
  import rgzc_pkg::*;

  // A run with no handshake at all for this many cycles is considered hung.
  // The longest legitimate silence is the deliberate receiver hold below plus
  // the settling time, so this leaves a wide margin.
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_STALL     = 300;
  localparam int SETTLE         = 20;

  typedef dist_t [GRID_COLS-1:0] row_cells_t;

  logic  clk = 1'b0;
  logic  rst;
  int    errors;
  int    pending;
  int    src_idle = 13;
  int    dst_idle = 48;
  bit    long_stall_req = 1'b0;
  int    quiet_cycles = 0;
  cfg_t  shadow;
  int unsigned target = 500;
  row_cells_t c;

  rgzc_row_if rows ();
  rgzc_out_if result ();
  rgzc_cfg_if cfg ();

  ranging_grid_zone_classifier u_top (
    .clk    (clk),
    .rst    (rst),
    .rows   (rows),
    .result (result),
    .cfg    (cfg)
  );

  rgzc_scoreboard u_checker (
    .clk     (clk),
    .rst     (rst),
    .rows    (rows),
    .result  (result),
    .cfg     (cfg),
    .errors  (errors),
    .pending (pending)
  );

  always #5 clk = ~clk;

  // Receiver. Normally ready is drawn afresh every cycle against dst_idle.
  // On request it holds ready low for a long stretch, so that the frame
  // queue inside the block fills and the row channel has to stall.
  initial begin
    result.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_stall_req) begin
        result.ready = 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        long_stall_req = 1'b0;
      end
      result.ready = ($urandom_range(99) >= dst_idle);
    end
  end

  // Watchdog: counts cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst || (rows.valid && rows.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One register write; called at a falling edge and returns at one. Valid is
  // left high so that back-to-back writes do not toggle it.
  task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input dist_t value);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      REG_MAX_RANGE:      shadow.max_range      = value;
      REG_IMMINENT_ENTER: shadow.imminent_enter = value;
      REG_IMMINENT_EXIT:  shadow.imminent_exit  = value;
      REG_NEAR_ENTER:     shadow.near_enter     = value;
      REG_NEAR_EXIT:      shadow.near_exit      = value;
      REG_FAR_ENTER:      shadow.far_enter      = value;
      REG_FAR_EXIT:       shadow.far_exit       = value;
      default:            shadow.smooth_weight  = value[WEIGHT_W-1:0];
    endcase
  endtask

  task automatic load_regs(input dist_t mr, input dist_t ie, input dist_t ix,
                           input dist_t ne, input dist_t nx, input dist_t fe,
                           input dist_t fx, input dist_t w);
    put_reg(REG_MAX_RANGE, mr);
    put_reg(REG_IMMINENT_ENTER, ie);
    put_reg(REG_IMMINENT_EXIT, ix);
    put_reg(REG_NEAR_ENTER, ne);
    put_reg(REG_NEAR_EXIT, nx);
    put_reg(REG_FAR_ENTER, fe);
    put_reg(REG_FAR_EXIT, fx);
    put_reg(REG_SMOOTH_WEIGHT, w);
    cfg.valid = 1'b0;
  endtask

  // Offers one row item, idling first as the current sender rate asks.
  task automatic send_row(input logic m, input logic [ROW_W-1:0] r, input row_cells_t cells);
    while ($urandom_range(99) < src_idle) begin
      rows.valid = 1'b0;
      @(negedge clk);
    end
    rows.valid     = 1'b1;
    rows.mode      = m;
    rows.row_index = r;
    rows.cell0     = cells[0];
    rows.cell1     = cells[1];
    rows.cell2     = cells[2];
    rows.cell3     = cells[3];
    rows.cell4     = cells[4];
    rows.cell5     = cells[5];
    rows.cell6     = cells[6];
    rows.cell7     = cells[7];
    @(posedge clk);
    while (!rows.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Stops offering rows until every outstanding result has come back, then
  // lets the back end settle so that the block is truly idle.
  task automatic drain();
    rows.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // A cell is mostly a distance a little beyond the frame's target, with
  // zeros, no-reading codes, full-range noise and values on the range limit
  // mixed in.
  function automatic dist_t pick_cell();
    int unsigned r, v;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 8) return NO_READING;
    if (r < 13) return dist_t'($urandom);
    if (r < 15) return shadow.max_range;
    if (r < 17) return shadow.max_range + 1'b1;
    v = target + $urandom_range(300);
    return (v > 65534) ? 16'd65534 : dist_t'(v);
  endfunction

  function automatic row_cells_t row_cells();
    row_cells_t cells;
    for (int k = 0; k < GRID_COLS; k++) cells[k] = pick_cell();
    return cells;
  endfunction

  // Keeps or moves the target distance: anywhere up to a margin past the far
  // exit or around a threshold, so that the hysteresis edges get exercised.
  task automatic new_target();
    int unsigned span, t;
    if ($urandom_range(99) < 40) return;
    if ($urandom_range(1)) begin
      span = shadow.far_exit + shadow.far_exit / 4 + 200;
      target = $urandom_range(span > 65534 ? 65534 : span);
    end else begin
      case ($urandom_range(5))
        0: t = shadow.imminent_enter;
        1: t = shadow.imminent_exit;
        2: t = shadow.near_enter;
        3: t = shadow.near_exit;
        4: t = shadow.far_enter;
        default: t = shadow.far_exit;
      endcase
      target = (t > 150) ? t - 150 + $urandom_range(200) : $urandom_range(200);
    end
  endtask

  // A well-formed frame of rows 0 to 7; now and then a read failure replaces
  // one row, which drops whatever was gathered so far.
  task automatic send_frame();
    new_target();
    for (int r = 0; r < GRID_ROWS; r++) begin
      if ($urandom_range(99) < 2)
        send_row(1'b1, ROW_W'($urandom_range(GRID_ROWS - 1)), row_cells());
      else
        send_row(1'b0, ROW_W'(r), row_cells());
    end
  endtask

  // Mostly whole frames with random content; the rest is a short burst of
  // rows in any order, failures among them.
  task automatic run_phase(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 85) begin
        send_frame();
        sent += GRID_ROWS;
      end else begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_row($urandom_range(99) < 15, ROW_W'($urandom_range(GRID_ROWS - 1)),
                   row_cells());
        sent += n;
      end
    end
  endtask

  initial begin
    int unsigned ie, ix, ne, nx, fe, fx;
    rst            = 1'b1;
    rows.valid     = 1'b0;
    rows.mode      = 1'b0;
    rows.row_index = '0;
    rows.cell0     = '0;
    rows.cell1     = '0;
    rows.cell2     = '0;
    rows.cell3     = '0;
    rows.cell4     = '0;
    rows.cell5     = '0;
    rows.cell6     = '0;
    rows.cell7     = '0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_MAX_RANGE;
    cfg.data       = '0;
    shadow = '{RST_MAX_RANGE, RST_IMMINENT_ENTER, RST_IMMINENT_EXIT, RST_NEAR_ENTER,
               RST_NEAR_EXIT, RST_FAR_ENTER, RST_FAR_EXIT, RST_SMOOTH_WEIGHT};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed frames under the reset settings. Concatenations list column 7
    // first. Row 0 carries a zero cell, cells on and just past the range
    // limit and a no-reading code; rows 4 to 7 put their smallest cells in
    // columns 0 and 7, which count for the whole frame but not the waist.
    // The same frame twice confirms the imminent zone on the second pass.
    for (int round = 0; round < 2; round++) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        if (r == 0)
          c = {16'd3000, 16'd2000, 16'd1000, 16'd300, NO_READING, 16'd4001, 16'd4000, 16'd0};
        else if (r < HEAD_ROWS)
          c = {GRID_COLS{16'd5000}};
        else
          c = {16'd160, {6{16'd700 + 16'(r)}}, 16'd150};
        send_row(1'b0, ROW_W'(r), c);
      end
    end
    // A failure in the middle of a frame, then one on its own.
    send_row(1'b0, 3'd0, {GRID_COLS{16'd1}});
    send_row(1'b1, 3'd5, {GRID_COLS{16'hFFFF}});
    send_row(1'b1, 3'd0, {GRID_COLS{16'd0}});
    // A closing row that is all zeros: no reading, so the zone state clears.
    send_row(1'b0, LAST_ROW, {GRID_COLS{16'd0}});
    // Rows out of order; the closing row only holds ignored cells.
    send_row(1'b0, 3'd6, {GRID_COLS{16'd900}});
    send_row(1'b0, 3'd2, {GRID_COLS{16'd1200}});
    send_row(1'b0, LAST_ROW, {GRID_COLS{NO_READING}});
    // The smallest distance that counts.
    send_row(1'b0, LAST_ROW, {GRID_COLS{16'd1}});

    run_phase(200);
    drain();

    // Every nonzero cell value counts, a no-reading code included; no smoothing.
    load_regs(16'd65535, RST_IMMINENT_ENTER, RST_IMMINENT_EXIT, RST_NEAR_ENTER,
              RST_NEAR_EXIT, RST_FAR_ENTER, RST_FAR_EXIT, 16'd256);
    run_phase(100);
    // Closing rows back to back while the receiver holds off: the queue
    // fills and the row channel has to stall until the hold ends.
    long_stall_req = 1'b1;
    repeat (24) send_row(1'b0, LAST_ROW, row_cells());
    // Sender pause until everything is back, then more traffic.
    drain();
    run_phase(100);
    drain();

    // Low extremes: nothing passes the range limit, zero thresholds and
    // weight.
    load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(48);
    drain();

    // High extremes, with a weight above one that must saturate.
    src_idle = 48;
    dst_idle = 13;
    load_regs(16'd65534, 16'd65534, 16'd65534, 16'd65534, 16'd65534, 16'd65534,
              16'd65535, 16'hFFFF);
    run_phase(150);
    drain();

    // Ordered thresholds at random spacing; the weight write carries random
    // upper data bits, which the register must drop.
    ie = $urandom_range(400);
    ix = ie + $urandom_range(100);
    ne = ix + $urandom_range(400);
    nx = ne + $urandom_range(200);
    fe = nx + $urandom_range(600);
    fx = fe + $urandom_range(200);
    load_regs(dist_t'($urandom_range(1000, 65535)), dist_t'(ie), dist_t'(ix),
              dist_t'(ne), dist_t'(nx), dist_t'(fe), dist_t'(fx), dist_t'($urandom));
    run_phase(250);
    drain();

    // Fully random settings, thresholds in any order.
    src_idle = 0;
    dst_idle = 0;
    load_regs(dist_t'($urandom), dist_t'($urandom), dist_t'($urandom), dist_t'($urandom),
              dist_t'($urandom), dist_t'($urandom), dist_t'($urandom), dist_t'($urandom));
    run_phase(200);
    drain();

    // Back to the defaults at full rate.
    load_regs(RST_MAX_RANGE, RST_IMMINENT_ENTER, RST_IMMINENT_EXIT, RST_NEAR_ENTER,
              RST_NEAR_EXIT, RST_FAR_ENTER, RST_FAR_EXIT, 16'(RST_SMOOTH_WEIGHT));
    run_phase(250);
    drain();

    if (errors == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
sv/rgzc_pkg.sv
sv/rgzc_ifs.sv
sv/rgzc_front.sv
sv/rgzc_queue.sv
sv/rgzc_back.sv
sv/ranging_grid_zone_classifier.sv
sv/rgzc_checker.sv
tb/rgzc_checker.sv
tb/tb.sv
